@@ rtl/core/spi_mbe_pkg.sv @@
package spi_mbe_pkg;

  typedef enum logic [1:0] {
    ACT_TICK        = 2'd0,
    ACT_WRITE_DATA  = 2'd1,
    ACT_READ_DATA   = 2'd2,
    ACT_READ_STATUS = 2'd3
  } action_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SELECT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RX_IRQ_EN   = 8'd3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [2:0] RATE_SEL_RESET = 3'd1;
  localparam logic [2:0] RATE_SEL_MAX   = 3'd6;
  localparam logic [3:0] LAST_EDGE      = 4'd15;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] write_data;
    logic       miso_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       done_flag;
    logic       sck_out;
    logic       mosi_out;
    logic       irq_out;
  } result_t;

  typedef struct packed {
    logic [1:0] clock_mode;
    logic       lsb_first;
    logic [2:0] rate_select;
    logic       rx_interrupt_enable;
  } cfg_t;

  // Announces a clock mode write so the idle clock level can follow at once.
  typedef struct packed {
    logic       mode_wr;
    logic [1:0] mode;
  } mode_wr_t;

endpackage

@@ rtl/core/spi_master_byte_engine.sv @@
// SPI master byte engine, modes 0 to 3. Each item is either a tick of the serial
// clock divider or a register access (write data, read data, read status), and
// every item produces exactly one result. The engine state updates in one pass at
// the accept edge and the result lands in an output register, so a new item is
// accepted every cycle as long as the result register is empty or being drained
// in the same cycle. Throughput is therefore one item per clock, and the result
// is valid in the cycle after accept. The serial clock runs at the tick rate
// divided by 2 << rate_select (rate seven acts as six). Configuration writes
// are taken every cycle and should be made only while no transfer is in flight.
module spi_master_byte_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  spi_mbe_pkg::item_t                  item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output spi_mbe_pkg::result_t                result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spi_mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spi_mbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spi_mbe_pkg::*;

  cfg_t     cfg;
  mode_wr_t mode_wr;
  result_t  step_result;
  logic     accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  spi_mbe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .mode_wr  (mode_wr)
  );

  spi_mbe_step u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .cfg     (cfg),
    .mode_wr (mode_wr),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_result;
    end
  end

endmodule

@@ rtl/core/spi_mbe_cfg.sv @@
module spi_mbe_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [spi_mbe_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [spi_mbe_pkg::CFG_DATA_W-1:0]  wr_data,
  output spi_mbe_pkg::cfg_t                   cfg,
  output spi_mbe_pkg::mode_wr_t               mode_wr
);
  import spi_mbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_mode          <= 2'd0;
      cfg.lsb_first           <= 1'b0;
      cfg.rate_select         <= RATE_SEL_RESET;
      cfg.rx_interrupt_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_CLOCK_MODE:  cfg.clock_mode          <= wr_data[1:0];
        CFG_LSB_FIRST:   cfg.lsb_first           <= wr_data[0];
        CFG_RATE_SELECT: cfg.rate_select         <= wr_data[2:0];
        CFG_RX_IRQ_EN:   cfg.rx_interrupt_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign mode_wr.mode_wr = wr_en && (wr_index == CFG_CLOCK_MODE);
  assign mode_wr.mode    = wr_data[1:0];

endmodule

@@ rtl/core/spi_mbe_step.sv @@
module spi_mbe_step (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  spi_mbe_pkg::item_t     item,
  input  spi_mbe_pkg::cfg_t      cfg,
  input  spi_mbe_pkg::mode_wr_t  mode_wr,
  output spi_mbe_pkg::result_t   result
);
  import spi_mbe_pkg::*;

  logic [7:0] shift_reg, shift_reg_next;
  logic [3:0] edge_count, edge_count_next;
  logic [5:0] divide_count, divide_count_next;
  logic       busy, busy_next;
  logic       done, done_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       clock_level, clock_level_next;
  logic       sample_bit, sample_bit_next;

  logic [2:0] rate_sat;
  logic [6:0] half_period;
  logic       cpha;
  logic       cpol;
  logic [7:0] rdata;

  function automatic logic [7:0] shift_byte(input logic [7:0] value, input logic in_bit,
                                             input logic lsb);
    logic [7:0] res;
    if (lsb) begin
      res = {in_bit, value[7:1]};
    end else begin
      res = {value[6:0], in_bit};
    end
    return res;
  endfunction

  assign rate_sat    = (cfg.rate_select > RATE_SEL_MAX) ? RATE_SEL_MAX : cfg.rate_select;
  assign half_period = 7'd1 << rate_sat;
  assign cpha        = cfg.clock_mode[0];
  assign cpol        = cfg.clock_mode[1];

  always_comb begin
    shift_reg_next    = shift_reg;
    edge_count_next   = edge_count;
    divide_count_next = divide_count;
    busy_next         = busy;
    done_next         = done;
    rx_hold_next      = rx_hold;
    clock_level_next  = clock_level;
    sample_bit_next   = sample_bit;
    rdata             = 8'd0;

    if (accept) begin
      unique case (action_t'(item.action))
        ACT_TICK: begin
          if (busy) begin
            if ({1'b0, divide_count} + 7'd1 >= half_period) begin
              divide_count_next = 6'd0;
              clock_level_next  = ~clock_level;
              // The sampling edge latches miso, and in trailing-edge sampling the last one also shifts
              // it in; the other edge shifts, except the first in that mode, which has nothing yet.
              if (edge_count[0] == cpha) begin
                sample_bit_next = item.miso_in;
                if (cpha && (edge_count == LAST_EDGE)) begin
                  shift_reg_next = shift_byte(shift_reg, item.miso_in, cfg.lsb_first);
                end
              end else if (!(cpha && (edge_count == 4'd0))) begin
                shift_reg_next = shift_byte(shift_reg, sample_bit, cfg.lsb_first);
              end
              if (edge_count == LAST_EDGE) begin
                busy_next         = 1'b0;
                done_next         = 1'b1;
                rx_hold_next      = shift_reg_next;
                edge_count_next   = 4'd0;
                divide_count_next = 6'd0;
                clock_level_next  = cpol;
              end else begin
                edge_count_next = edge_count + 4'd1;
              end
            end else begin
              divide_count_next = divide_count + 6'd1;
            end
          end
        end
        ACT_WRITE_DATA: begin
          if (!busy) begin
            shift_reg_next    = item.write_data;
            busy_next         = 1'b1;
            edge_count_next   = 4'd0;
            divide_count_next = 6'd0;
            sample_bit_next   = 1'b0;
            clock_level_next  = cpol;
          end
        end
        ACT_READ_DATA: begin
          rdata     = rx_hold;
          done_next = 1'b0;
        end
        ACT_READ_STATUS: begin
          rdata = {done, 7'd0};
        end
        default: ;
      endcase
    end

    // An idle clock follows a mode write immediately.
    if (mode_wr.mode_wr && !busy_next) begin
      clock_level_next = mode_wr.mode[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg    <= 8'd0;
      edge_count   <= 4'd0;
      divide_count <= 6'd0;
      busy         <= 1'b0;
      done         <= 1'b0;
      rx_hold      <= 8'd0;
      clock_level  <= 1'b0;
      sample_bit   <= 1'b0;
    end else begin
      shift_reg    <= shift_reg_next;
      edge_count   <= edge_count_next;
      divide_count <= divide_count_next;
      busy         <= busy_next;
      done         <= done_next;
      rx_hold      <= rx_hold_next;
      clock_level  <= clock_level_next;
      sample_bit   <= sample_bit_next;
    end
  end

  assign result.read_data = rdata;
  assign result.done_flag = done_next;
  assign result.sck_out   = clock_level_next;
  assign result.mosi_out  = cfg.lsb_first ? shift_reg_next[0] : shift_reg_next[7];
  assign result.irq_out   = done_next & cfg.rx_interrupt_enable;

  a_end_sets_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("transfer ended without setting done");

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (edge_count == 4'd0) && (divide_count == 6'd0))
    else $error("counters not cleared while idle");

  a_idle_clock_level: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (clock_level == cfg.clock_mode[1]))
    else $error("idle clock level differs from clock polarity");

endmodule
